// ----- hw/rtl/bta_pkg.sv -----
package bta_pkg;

   localparam int BLOCK_COUNT   = 256;
   localparam int BLOCK_BYTES   = 32;
   localparam int POOL_BYTES    = BLOCK_COUNT * BLOCK_BYTES;
   localparam int PERCENT_SCALE = 100;

   localparam int IDX_W    = $clog2(BLOCK_COUNT);
   localparam int CNT_W    = $clog2(BLOCK_COUNT + 1);
   localparam int OPCODE_W = 2;
   localparam int REQ_W    = 20;
   localparam int STATUS_W = 2;
   localparam int OFFSET_W = 13;
   localparam int USAGE_W  = 7;
   localparam int SCALE_W  = $clog2(PERCENT_SCALE + 1);

   typedef enum logic [OPCODE_W-1:0] {
      OP_ALLOC = 2'd0,
      OP_FREE  = 2'd1,
      OP_USAGE = 2'd2
   } opcode_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK        = 2'd0,
      STAT_NO_RUN    = 2'd1,
      STAT_ZERO_SIZE = 2'd2,
      STAT_IGNORED   = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      CMD_NONE,
      CMD_LOAD,
      CMD_SCAN,
      CMD_MARK,
      CMD_FREE,
      CMD_RESPOND
   } cmd_type;

   typedef struct packed {
      cmd_type cmd;
   } ctrl_cmd_type;

   typedef struct packed {
      logic skip;
      logic is_alloc;
      logic hit;
      logic scan_fail;
      logic mark_last;
      logic free_done;
      logic rsp_free;
   } dp_status_type;

endpackage

// ----- hw/rtl/bta_req_if.sv -----
interface bta_req_if;
   logic                          valid;
   logic                          ready;
   logic [bta_pkg::OPCODE_W-1:0]  opcode;
   logic [bta_pkg::REQ_W-1:0]     request_bytes;
   logic [bta_pkg::REQ_W-1:0]     free_offset;

   modport source (output valid, output opcode, output request_bytes, output free_offset,
                   input ready);
   modport sink (input valid, input opcode, input request_bytes, input free_offset,
                 output ready);
endinterface

// ----- hw/rtl/bta_rsp_if.sv -----
interface bta_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [bta_pkg::STATUS_W-1:0]  status;
   logic [bta_pkg::OFFSET_W-1:0]  byte_offset;
   logic [bta_pkg::USAGE_W-1:0]   usage_percent;

   modport source (output valid, output status, output byte_offset, output usage_percent,
                   input ready);
   modport sink (input valid, input status, input byte_offset, input usage_percent,
                 output ready);
endinterface

// ----- hw/rtl/bta_ram.sv -----
module bta_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hw/rtl/bta_ctrl.sv -----
module bta_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  bta_pkg::dp_status_type status,
   output bta_pkg::ctrl_cmd_type  cmd
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_DISPATCH,
      S_SCAN,
      S_MARK,
      S_FREE,
      S_RESULT
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      ready_ff;

   always_comb begin
      state_in = state_ff;
      cmd.cmd  = bta_pkg::CMD_NONE;
      case (state_ff)
         S_IDLE: begin
            if (req_valid && ready_ff) begin
               cmd.cmd  = bta_pkg::CMD_LOAD;
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            if (status.skip) begin
               state_in = S_RESULT;
            end else if (status.is_alloc) begin
               state_in = S_SCAN;
            end else begin
               state_in = S_FREE;
            end
         end
         S_SCAN: begin
            cmd.cmd = bta_pkg::CMD_SCAN;
            if (status.hit) begin
               state_in = S_MARK;
            end else if (status.scan_fail) begin
               state_in = S_RESULT;
            end
         end
         S_MARK: begin
            cmd.cmd = bta_pkg::CMD_MARK;
            if (status.mark_last) begin
               state_in = S_RESULT;
            end
         end
         S_FREE: begin
            cmd.cmd = bta_pkg::CMD_FREE;
            if (status.free_done) begin
               state_in = S_RESULT;
            end
         end
         S_RESULT: begin
            if (status.rsp_free) begin
               cmd.cmd  = bta_pkg::CMD_RESPOND;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ready_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         ready_ff <= (state_in == S_IDLE);
      end
   end

   assign req_ready = ready_ff;

endmodule

// ----- hw/rtl/bta_datapath.sv -----
module bta_datapath (
   input  logic                          clock,
   input  logic                          reset,
   input  bta_pkg::ctrl_cmd_type         cmd,
   output bta_pkg::dp_status_type        status,
   input  logic [bta_pkg::OPCODE_W-1:0]  req_opcode,
   input  logic [bta_pkg::REQ_W-1:0]     req_request_bytes,
   input  logic [bta_pkg::REQ_W-1:0]     req_free_offset,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [bta_pkg::STATUS_W-1:0]  rsp_status,
   output logic [bta_pkg::OFFSET_W-1:0]  rsp_byte_offset,
   output logic [bta_pkg::USAGE_W-1:0]   rsp_usage_percent
);

   localparam int IDX_W = bta_pkg::IDX_W;
   localparam int CNT_W = bta_pkg::CNT_W;
   localparam int SUM_W = bta_pkg::REQ_W + 1;
   localparam int PROD_W = CNT_W + bta_pkg::SCALE_W;

   logic [bta_pkg::OPCODE_W-1:0] op_ff;
   logic                         skip_ff;
   bta_pkg::status_type          stat_ff;
   logic [bta_pkg::OFFSET_W-1:0] offset_ff;
   logic [CNT_W-1:0]             need_ff;
   logic [IDX_W-1:0]             addr_ff;
   logic                         more_ff;
   logic                         chk_vld_ff;
   logic [IDX_W-1:0]             chk_addr_ff;
   logic [CNT_W-1:0]             run_ff;
   logic [CNT_W-1:0]             remain_ff;
   logic                         head_ff;
   logic [IDX_W-1:0]             wr_addr_ff;
   logic [CNT_W-1:0]             used_ff;
   logic [bta_pkg::BLOCK_COUNT-1:0] valid_ff;
   logic                         rd_valid_ff;

   logic                         rsp_valid_ff;
   logic [bta_pkg::STATUS_W-1:0] rsp_status_ff;
   logic [bta_pkg::OFFSET_W-1:0] rsp_offset_ff;
   logic [bta_pkg::USAGE_W-1:0]  rsp_usage_ff;

   logic [SUM_W-1:0]  byte_sum;
   logic [SUM_W-1:0]  need_full;
   logic              too_big;
   logic              out_of_pool;
   logic [CNT_W-1:0]  ram_q;
   logic [CNT_W-1:0]  entry;
   logic [CNT_W-1:0]  run_step;
   logic [CNT_W-1:0]  remain_eff;
   logic              hit;
   logic              free_work;
   logic              free_clear;
   logic              ram_wr_en;
   logic [IDX_W-1:0]  ram_wr_addr;
   logic [CNT_W-1:0]  ram_wr_data;
   logic [PROD_W-1:0] usage_prod;
   logic [bta_pkg::USAGE_W-1:0] usage_calc;

   assign byte_sum    = SUM_W'(req_request_bytes) + SUM_W'(bta_pkg::BLOCK_BYTES - 1);
   assign need_full   = SUM_W'(byte_sum / bta_pkg::BLOCK_BYTES);
   assign too_big     = need_full > SUM_W'(bta_pkg::BLOCK_COUNT);
   assign out_of_pool = SUM_W'(req_free_offset) >= SUM_W'(bta_pkg::POOL_BYTES);

   assign entry      = rd_valid_ff ? ram_q : '0;
   assign run_step   = (entry == '0) ? run_ff + 1'b1 : '0;
   assign hit        = (cmd.cmd == bta_pkg::CMD_SCAN) && chk_vld_ff && (run_step == need_ff);
   assign remain_eff = head_ff ? entry : remain_ff;
   assign free_work  = (cmd.cmd == bta_pkg::CMD_FREE) && chk_vld_ff && (remain_eff != '0);
   assign free_clear = free_work && (entry != '0);

   assign usage_prod = PROD_W'(used_ff) * PROD_W'(bta_pkg::PERCENT_SCALE);
   assign usage_calc = bta_pkg::USAGE_W'(usage_prod / bta_pkg::BLOCK_COUNT);

   always_comb begin
      ram_wr_en   = 1'b0;
      ram_wr_addr = wr_addr_ff;
      ram_wr_data = need_ff;
      if (cmd.cmd == bta_pkg::CMD_MARK) begin
         ram_wr_en = 1'b1;
      end else if (free_clear) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = chk_addr_ff;
         ram_wr_data = '0;
      end
   end

   bta_ram #(
      .WIDTH (CNT_W),
      .DEPTH (bta_pkg::BLOCK_COUNT)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (addr_ff),
      .rd_data (ram_q)
   );

   always_comb begin
      status.skip      = skip_ff;
      status.is_alloc  = (op_ff == bta_pkg::OP_ALLOC);
      status.hit       = hit;
      status.scan_fail = (cmd.cmd == bta_pkg::CMD_SCAN) && chk_vld_ff && !hit
                         && (chk_addr_ff == '0);
      status.mark_last = (remain_ff == CNT_W'(1));
      status.free_done = (cmd.cmd == bta_pkg::CMD_FREE) && chk_vld_ff
                         && ((remain_eff == '0) || (remain_eff == CNT_W'(1))
                             || (chk_addr_ff == IDX_W'(bta_pkg::BLOCK_COUNT - 1)));
      status.rsp_free  = !rsp_valid_ff || rsp_ready;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff      <= '0;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (ram_wr_en) begin
            valid_ff[ram_wr_addr] <= 1'b1;
         end
         if (hit) begin
            used_ff <= used_ff + need_ff;
         end else if (free_clear && (used_ff != '0)) begin
            used_ff <= used_ff - 1'b1;
         end
         if (cmd.cmd == bta_pkg::CMD_RESPOND) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      rd_valid_ff <= valid_ff[addr_ff];
      case (cmd.cmd)
         bta_pkg::CMD_LOAD: begin
            op_ff      <= req_opcode;
            need_ff    <= CNT_W'(need_full);
            offset_ff  <= '0;
            more_ff    <= 1'b1;
            chk_vld_ff <= 1'b0;
            run_ff     <= '0;
            head_ff    <= 1'b1;
            if (req_opcode == bta_pkg::OP_ALLOC) begin
               addr_ff <= IDX_W'(bta_pkg::BLOCK_COUNT - 1);
            end else begin
               addr_ff <= IDX_W'(req_free_offset / bta_pkg::BLOCK_BYTES);
            end
            case (req_opcode)
               bta_pkg::OP_ALLOC: begin
                  if (req_request_bytes == '0) begin
                     stat_ff <= bta_pkg::STAT_ZERO_SIZE;
                     skip_ff <= 1'b1;
                  end else begin
                     stat_ff <= bta_pkg::STAT_NO_RUN;
                     skip_ff <= too_big;
                  end
               end
               bta_pkg::OP_FREE: begin
                  stat_ff <= out_of_pool ? bta_pkg::STAT_IGNORED : bta_pkg::STAT_OK;
                  skip_ff <= out_of_pool;
               end
               bta_pkg::OP_USAGE: begin
                  stat_ff <= bta_pkg::STAT_OK;
                  skip_ff <= 1'b1;
               end
               default: begin
                  stat_ff <= bta_pkg::STAT_IGNORED;
                  skip_ff <= 1'b1;
               end
            endcase
         end
         bta_pkg::CMD_SCAN: begin
            chk_vld_ff  <= more_ff;
            chk_addr_ff <= addr_ff;
            if (more_ff) begin
               addr_ff <= addr_ff - 1'b1;
               if (addr_ff == '0) begin
                  more_ff <= 1'b0;
               end
            end
            if (chk_vld_ff) begin
               run_ff <= run_step;
            end
            if (hit) begin
               wr_addr_ff <= chk_addr_ff;
               remain_ff  <= need_ff;
               stat_ff    <= bta_pkg::STAT_OK;
               offset_ff  <= bta_pkg::OFFSET_W'(chk_addr_ff * bta_pkg::BLOCK_BYTES);
            end
         end
         bta_pkg::CMD_MARK: begin
            wr_addr_ff <= wr_addr_ff + 1'b1;
            remain_ff  <= remain_ff - 1'b1;
         end
         bta_pkg::CMD_FREE: begin
            chk_vld_ff  <= more_ff;
            chk_addr_ff <= addr_ff;
            if (more_ff) begin
               addr_ff <= addr_ff + 1'b1;
               if (addr_ff == IDX_W'(bta_pkg::BLOCK_COUNT - 1)) begin
                  more_ff <= 1'b0;
               end
            end
            if (chk_vld_ff) begin
               head_ff <= 1'b0;
            end
            if (free_work) begin
               remain_ff <= remain_eff - 1'b1;
            end
         end
         bta_pkg::CMD_RESPOND: begin
            rsp_status_ff <= stat_ff;
            rsp_offset_ff <= offset_ff;
            rsp_usage_ff  <= (op_ff == bta_pkg::OP_USAGE) ? usage_calc : '0;
         end
         default: begin
         end
      endcase
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_byte_offset   = rsp_offset_ff;
   assign rsp_usage_percent = rsp_usage_ff;

endmodule

// ----- hw/rtl/block_table_allocator_top.sv -----
// Block-table allocator for a pool of 256 blocks of 32 bytes, one table word per block, handled
// one request at a time, with one table RAM read and at most one write per cycle. A usage query
// or a rejected request goes from dispatch straight to its response word, with no table pass.
// An allocate scans the table from the top block down, one entry a cycle, and then writes one
// entry a cycle for each block taken. A free walks one entry a cycle from the given block for as
// many entries as the stored count says, up to the end of the table, and walks at least one
// entry. After reset the table reads as all free without any clearing pass. A new request is
// accepted while the previous response word still waits to be taken.
module block_table_allocator_top (
   input logic        clock,
   input logic        reset,
   bta_req_if.sink    req_chan,
   bta_rsp_if.source  rsp_chan
);

   bta_pkg::ctrl_cmd_type  cmd;
   bta_pkg::dp_status_type status;

   bta_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   bta_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_opcode        (req_chan.opcode),
      .req_request_bytes (req_chan.request_bytes),
      .req_free_offset   (req_chan.free_offset),
      .rsp_valid         (rsp_chan.valid),
      .rsp_ready         (rsp_chan.ready),
      .rsp_status        (rsp_chan.status),
      .rsp_byte_offset   (rsp_chan.byte_offset),
      .rsp_usage_percent (rsp_chan.usage_percent)
   );

endmodule

// ----- bench/block_table_allocator_top_test.sv -----
module block_table_allocator_top_test;

   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [bta_pkg::OPCODE_W-1:0] OP_UNUSED = 2'd3;
   localparam int RANDOM_REQUESTS = 1150;
   localparam int DRAIN_CYCLES = 600;
   localparam int CYCLE_LIMIT = 4000000;
   localparam logic [bta_pkg::REQ_W-1:0] REQ_MASK = {bta_pkg::REQ_W{1'b1}};

   typedef struct {
      logic [bta_pkg::OPCODE_W-1:0] opcode;
      logic [bta_pkg::REQ_W-1:0]    request_bytes;
      logic [bta_pkg::REQ_W-1:0]    free_offset;
   } alloc_request_type;

   typedef struct {
      bta_pkg::status_type          status;
      logic [bta_pkg::OFFSET_W-1:0] byte_offset;
      logic [bta_pkg::USAGE_W-1:0]  usage_percent;
   } alloc_response_type;

   logic clock;
   logic reset;

   bta_req_if req_bus ();
   bta_rsp_if rsp_bus ();

   block_table_allocator_top dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   logic [bta_pkg::CNT_W-1:0] owner_count [bta_pkg::BLOCK_COUNT];
   int                        used_block_total;
   int                        live_run_offsets[$];
   alloc_request_type         request_backlog[$];
   alloc_response_type        pending_responses[$];
   int                        failures = 0;
   int                        cycle_count = 0;
   int                        burst_left = 1;
   int                        gap_left = 0;
   int                        stall_phase_left = 0;
   logic [15:0]               stall_pattern = 16'hFFFF;
   logic [3:0]                stall_bit = 4'd0;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      req_bus.valid = 1'b0;
      req_bus.opcode = bta_pkg::OP_USAGE;
      req_bus.request_bytes = '0;
      req_bus.free_offset = '0;
      rsp_bus.ready = 1'b0;
      for (int i = 0; i < bta_pkg::BLOCK_COUNT; i++) begin
         owner_count[i] = '0;
      end
      used_block_total = 0;
   end

   function automatic alloc_response_type allocator_outcome(
      logic [bta_pkg::OPCODE_W-1:0] opcode,
      logic [bta_pkg::REQ_W-1:0] bytes,
      logic [bta_pkg::REQ_W-1:0] offset);
      alloc_response_type outcome;
      int needed;
      int run_length;
      int block;
      int start;
      int stored;
      bit found;
      outcome.status = bta_pkg::STAT_OK;
      outcome.byte_offset = '0;
      outcome.usage_percent = '0;
      case (opcode)
         bta_pkg::OP_ALLOC: begin
            needed = (int'(bytes) + bta_pkg::BLOCK_BYTES - 1) / bta_pkg::BLOCK_BYTES;
            if (bytes == '0) begin
               outcome.status = bta_pkg::STAT_ZERO_SIZE;
            end else if (needed > bta_pkg::BLOCK_COUNT) begin
               outcome.status = bta_pkg::STAT_NO_RUN;
            end else begin
               run_length = 0;
               found = 1'b0;
               for (block = bta_pkg::BLOCK_COUNT - 1; block >= 0 && !found; block--) begin
                  run_length = (owner_count[block] == '0) ? run_length + 1 : 0;
                  if (run_length == needed) begin
                     found = 1'b1;
                     for (int k = 0; k < needed; k++) begin
                        owner_count[block + k] = bta_pkg::CNT_W'(needed);
                     end
                     used_block_total += needed;
                     outcome.byte_offset = bta_pkg::OFFSET_W'(block * bta_pkg::BLOCK_BYTES);
                     live_run_offsets.push_back(block * bta_pkg::BLOCK_BYTES);
                  end
               end
               if (!found) begin
                  outcome.status = bta_pkg::STAT_NO_RUN;
               end
            end
         end
         bta_pkg::OP_FREE: begin
            if (int'(offset) >= bta_pkg::POOL_BYTES) begin
               outcome.status = bta_pkg::STAT_IGNORED;
            end else begin
               start = int'(offset) / bta_pkg::BLOCK_BYTES;
               stored = int'(owner_count[start]);
               for (int k = 0; k < stored && start + k < bta_pkg::BLOCK_COUNT; k++) begin
                  if (owner_count[start + k] != '0) begin
                     owner_count[start + k] = '0;
                     if (used_block_total > 0) begin
                        used_block_total--;
                     end
                  end
               end
            end
         end
         bta_pkg::OP_USAGE: begin
            outcome.usage_percent = bta_pkg::USAGE_W'(used_block_total *
                                                      bta_pkg::PERCENT_SCALE /
                                                      bta_pkg::BLOCK_COUNT);
         end
         default: begin
            outcome.status = bta_pkg::STAT_IGNORED;
         end
      endcase
      return outcome;
   endfunction

   function automatic alloc_request_type make_request(logic [bta_pkg::OPCODE_W-1:0] opcode,
                                                      int unsigned bytes,
                                                      int unsigned offset);
      alloc_request_type item;
      item.opcode = opcode;
      item.request_bytes = bta_pkg::REQ_W'(bytes);
      item.free_offset = bta_pkg::REQ_W'(offset);
      return item;
   endfunction

   function automatic alloc_request_type random_request();
      alloc_request_type item;
      int alloc_cut;
      int free_cut;
      int pick;
      int size_pick;
      int slot;
      item.request_bytes = bta_pkg::REQ_W'($urandom) & REQ_MASK;
      item.free_offset = bta_pkg::REQ_W'($urandom) & REQ_MASK;
      alloc_cut = (live_run_offsets.size() > 16) ? 25 : 45;
      free_cut = 75;
      pick = $urandom_range(0, 99);
      if (pick < alloc_cut) begin
         item.opcode = bta_pkg::OP_ALLOC;
         size_pick = $urandom_range(0, 99);
         if (size_pick < 2) begin
            item.request_bytes = '0;
         end else if (size_pick < 10) begin
            item.request_bytes = bta_pkg::REQ_W'($urandom_range(1, bta_pkg::POOL_BYTES));
         end else if (size_pick >= 5 + 5) begin
            item.request_bytes = bta_pkg::REQ_W'($urandom_range(1, 640));
         end
      end else if (pick < free_cut && live_run_offsets.size() > 0) begin
         item.opcode = bta_pkg::OP_FREE;
         slot = $urandom_range(0, live_run_offsets.size() - 1);
         item.free_offset = bta_pkg::REQ_W'(live_run_offsets[slot]);
         if ($urandom_range(0, 4) == 0) begin
            item.free_offset = bta_pkg::REQ_W'((live_run_offsets[slot] +
                                                $urandom_range(0, 95)) %
                                               bta_pkg::POOL_BYTES);
         end
         live_run_offsets.delete(slot);
      end else if (pick < free_cut + 8) begin
         item.opcode = bta_pkg::OP_FREE;
         if ($urandom_range(0, 1) == 0) begin
            item.free_offset = bta_pkg::REQ_W'($urandom_range(0, bta_pkg::POOL_BYTES - 1));
         end
      end else if (pick < free_cut + 18) begin
         item.opcode = bta_pkg::OP_USAGE;
      end else begin
         item.opcode = OP_UNUSED;
      end
      return item;
   endfunction

   initial begin
      reset = 1'b1;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Edge cases: empty table, bad sizes, frees outside the pool, frees that run into a
      // neighboring allocation or past the end of the table, and a completely full pool.
      request_backlog.push_back(make_request(bta_pkg::OP_USAGE, 0, 0));
      request_backlog.push_back(make_request(OP_UNUSED, REQ_MASK, REQ_MASK));
      request_backlog.push_back(make_request(bta_pkg::OP_ALLOC, 0, 0));
      request_backlog.push_back(make_request(bta_pkg::OP_ALLOC, 1, 0));
      request_backlog.push_back(make_request(bta_pkg::OP_ALLOC, bta_pkg::BLOCK_BYTES, 0));
      request_backlog.push_back(make_request(bta_pkg::OP_ALLOC, bta_pkg::BLOCK_BYTES + 1, 0));
      request_backlog.push_back(make_request(bta_pkg::OP_ALLOC, REQ_MASK, 0));
      request_backlog.push_back(make_request(bta_pkg::OP_ALLOC, bta_pkg::POOL_BYTES + 1, 0));
      request_backlog.push_back(make_request(bta_pkg::OP_FREE, 0, bta_pkg::POOL_BYTES));
      request_backlog.push_back(make_request(bta_pkg::OP_FREE, 0, REQ_MASK));
      request_backlog.push_back(make_request(bta_pkg::OP_FREE, 0, 0));
      request_backlog.push_back(make_request(bta_pkg::OP_USAGE, 0, 0));
      request_backlog.push_back(make_request(bta_pkg::OP_FREE, 0, 8096));
      request_backlog.push_back(make_request(bta_pkg::OP_FREE, 0, 8160));
      request_backlog.push_back(make_request(bta_pkg::OP_FREE, 0, 8064));
      request_backlog.push_back(make_request(bta_pkg::OP_USAGE, 0, 0));
      request_backlog.push_back(make_request(bta_pkg::OP_ALLOC, bta_pkg::POOL_BYTES, 0));
      request_backlog.push_back(make_request(bta_pkg::OP_USAGE, 0, 0));
      request_backlog.push_back(make_request(bta_pkg::OP_ALLOC, 1, 0));
      request_backlog.push_back(make_request(bta_pkg::OP_FREE, 0,
                                             31 * bta_pkg::BLOCK_BYTES + 5));
      request_backlog.push_back(make_request(bta_pkg::OP_FREE, 0, 0));
      request_backlog.push_back(make_request(bta_pkg::OP_ALLOC, 3 * bta_pkg::BLOCK_BYTES, 0));
      request_backlog.push_back(make_request(bta_pkg::OP_FREE, 0, 8135));
      request_backlog.push_back(make_request(bta_pkg::OP_FREE, 0, 8096));
      request_backlog.push_back(make_request(bta_pkg::OP_USAGE, 0, 0));

      for (int n = 0; n < RANDOM_REQUESTS; n++) begin
         while (request_backlog.size() > 1) begin
            @(posedge clock);
         end
         request_backlog.push_back(random_request());
      end

      while (request_backlog.size() > 0 || req_bus.valid || pending_responses.size() > 0) begin
         @(negedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (failures == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   always @(posedge clock) begin
      alloc_request_type next_item;
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            pending_responses.push_back(allocator_outcome(req_bus.opcode,
                                                          req_bus.request_bytes,
                                                          req_bus.free_offset));
         end
         if (req_bus.valid && !req_bus.ready) begin
            req_bus.valid <= 1'b1;
         end else if (gap_left > 0) begin
            gap_left--;
            req_bus.valid <= 1'b0;
         end else if (request_backlog.size() > 0) begin
            next_item = request_backlog.pop_front();
            req_bus.valid <= 1'b1;
            req_bus.opcode <= next_item.opcode;
            req_bus.request_bytes <= next_item.request_bytes;
            req_bus.free_offset <= next_item.free_offset;
            if (burst_left > 1) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(1, 20);
               gap_left = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 12);
            end
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (stall_phase_left == 0) begin
            stall_phase_left = $urandom_range(50, 400);
            case ($urandom_range(0, 2))
               0: stall_pattern = 16'hFFFF;
               1: stall_pattern = 16'($urandom);
               default: stall_pattern = 16'($urandom) & 16'($urandom);
            endcase
         end else begin
            stall_phase_left--;
         end
         rsp_bus.ready <= stall_pattern[stall_bit];
         stall_bit <= stall_bit + 4'd1;
      end
   end

   always @(posedge clock) begin
      alloc_response_type expected;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_responses.size() == 0) begin
            $error("Response word arrived with no request outstanding.");
            failures++;
         end else begin
            expected = pending_responses.pop_front();
            if (rsp_bus.status !== expected.status) begin
               $error("status: expected %0d, got %0d", expected.status, rsp_bus.status);
               failures++;
            end
            if (rsp_bus.byte_offset !== expected.byte_offset) begin
               $error("byte_offset: expected %0d, got %0d",
                      expected.byte_offset, rsp_bus.byte_offset);
               failures++;
            end
            if (rsp_bus.usage_percent !== expected.usage_percent) begin
               $error("usage_percent: expected %0d, got %0d",
                      expected.usage_percent, rsp_bus.usage_percent);
               failures++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

endmodule

// ----- files.f -----
hw/rtl/bta_pkg.sv
hw/rtl/bta_req_if.sv
hw/rtl/bta_rsp_if.sv
hw/rtl/bta_ram.sv
hw/rtl/bta_ctrl.sv
hw/rtl/bta_datapath.sv
hw/rtl/block_table_allocator_top.sv
bench/block_table_allocator_top_test.sv
